@@ sv/sexp_tok_pkg.sv @@
// ----------------------------------------------------------------------------
// sexp_tok_pkg
// Shared types, codes and character classes of the S-expression tokenizer.
// ----------------------------------------------------------------------------
package sexp_tok_pkg;

    localparam int QUEUE_DEPTH_DEFAULT = 4;

    localparam logic [23:0] LINE_MAX = 24'hFF_FFFF;
    localparam logic [15:0] COL_MAX  = 16'hFFFF;
    localparam logic [15:0] LEN_MAX  = 16'hFFFF;

    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_OPEN   = 8'h28;
    localparam logic [7:0] CH_CLOSE  = 8'h29;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UZ     = 8'h5A;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LZ     = 8'h7A;

    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_END  = 1'b1;

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_IDENT  = 3'd1,
        MODE_NUMBER = 3'd2,
        MODE_SYMBOL = 3'd3,
        MODE_STRING = 3'd4
    } mode_t;

    typedef enum logic [3:0] {
        KIND_OPEN     = 4'd0,
        KIND_CLOSE    = 4'd1,
        KIND_IDENT    = 4'd2,
        KIND_NUMBER   = 4'd3,
        KIND_SYMBOL   = 4'd4,
        KIND_STRING   = 4'd5,
        KIND_END      = 4'd6,
        KIND_BAD      = 4'd7,
        KIND_UNCLOSED = 4'd8
    } kind_t;

    // Scanner position and mode; reset to idle at line 1, column 0, offset 0
    typedef struct packed {
        mode_t       mode;
        logic [23:0] line;
        logic [15:0] col;
        logic [31:0] off;
        logic        halted;
    } ctrl_t;

    // Pending token fields; written at token start before any read
    typedef struct packed {
        logic [23:0] line;
        logic [15:0] col;
        logic [31:0] off;
        logic [15:0] len;
        logic [31:0] acc;
    } tok_t;

    typedef struct packed {
        kind_t       kind;
        logic [23:0] line;
        logic [15:0] col;
        logic [31:0] off;
        logic [15:0] len;
        logic [31:0] val;
        logic        last;
    } res_t;

    // Results of one input item, first to second
    typedef struct packed {
        logic [1:0] count;
        res_t       first;
        res_t       second;
    } push_t;

    function automatic logic is_letter(input logic [7:0] b);
        return (b >= CH_LA && b <= CH_LZ) || (b >= CH_UA && b <= CH_UZ) || b == CH_UNDER;
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b >= CH_ZERO && b <= CH_NINE;
    endfunction

    function automatic logic is_name(input logic [7:0] b);
        return is_letter(b) || is_digit(b) || b == CH_BANG || b == CH_QMARK
            || b == CH_COLON;
    endfunction

    function automatic logic is_blank(input logic [7:0] b);
        return b == CH_SPACE || b == CH_NL || b == CH_TAB;
    endfunction

endpackage

@@ sv/sexp_tok_step.sv @@
// ----------------------------------------------------------------------------
// sexp_tok_step
// Next-state and token logic for one input transaction of the tokenizer.
// ----------------------------------------------------------------------------
module sexp_tok_step
    import sexp_tok_pkg::*;
(
    input  logic       action,
    input  logic [7:0] byte_req,
    input  ctrl_t      ctrl_cur,
    input  tok_t       tok_cur,
    output ctrl_t      ctrl_nxt,
    output tok_t       tok_nxt,
    output push_t      push
);

    logic  emit_pend;
    logic  emit_here;
    logic  fall;
    logic  adv;
    res_t  pend_res;
    res_t  here_res;
    kind_t pend_kind;
    logic [31:0] acc_x10;
    logic [31:0] digit_val;

    assign digit_val = {28'd0, byte_req[3:0] - CH_ZERO[3:0]};
    assign acc_x10   = {tok_cur.acc[28:0], 3'b000} + {tok_cur.acc[30:0], 1'b0};

    // Kind of the pending token follows the scan mode
    always_comb
    begin
        case (ctrl_cur.mode)
            MODE_NUMBER: pend_kind = KIND_NUMBER;
            MODE_SYMBOL: pend_kind = KIND_SYMBOL;
            MODE_STRING: pend_kind = KIND_STRING;
            default:     pend_kind = KIND_IDENT;
        endcase
    end

    // Scan one byte or end mark
    always_comb
    begin
        ctrl_nxt  = ctrl_cur;
        tok_nxt   = tok_cur;
        emit_pend = 1'b0;
        emit_here = 1'b0;
        fall      = 1'b0;
        adv       = 1'b0;

        pend_res.kind = pend_kind;
        pend_res.line = tok_cur.line;
        pend_res.col  = tok_cur.col;
        pend_res.off  = tok_cur.off;
        pend_res.len  = tok_cur.len;
        pend_res.val  = (ctrl_cur.mode == MODE_NUMBER) ? tok_cur.acc : 32'd0;
        pend_res.last = 1'b0;

        here_res.kind = KIND_END;
        here_res.line = ctrl_cur.line;
        here_res.col  = ctrl_cur.col;
        here_res.off  = ctrl_cur.off;
        here_res.len  = 16'd0;
        here_res.val  = 32'd0;
        here_res.last = 1'b1;

        if (ctrl_cur.halted)
        begin
            // Silent until reset
        end
        else if (action == ACT_END)
        begin
            if (ctrl_cur.mode == MODE_STRING)
            begin
                emit_here      = 1'b1;
                here_res       = pend_res;
                here_res.kind  = KIND_UNCLOSED;
                here_res.last  = 1'b1;
                ctrl_nxt.halted = 1'b1;
            end
            else
            begin
                emit_pend = (ctrl_cur.mode != MODE_IDLE);
                emit_here = 1'b1;
            end
            ctrl_nxt.mode = MODE_IDLE;
        end
        else
        begin
            // Extend or close the token in progress
            case (ctrl_cur.mode)
                MODE_IDENT, MODE_SYMBOL:
                begin
                    if (is_name(byte_req))
                    begin
                        tok_nxt.len = (tok_cur.len < LEN_MAX) ? tok_cur.len + 16'd1 : tok_cur.len;
                        adv = 1'b1;
                    end
                    else
                    begin
                        emit_pend     = 1'b1;
                        ctrl_nxt.mode = MODE_IDLE;
                        fall          = 1'b1;
                    end
                end
                MODE_NUMBER:
                begin
                    if (is_digit(byte_req))
                    begin
                        tok_nxt.acc = acc_x10 + digit_val;
                        tok_nxt.len = (tok_cur.len < LEN_MAX) ? tok_cur.len + 16'd1 : tok_cur.len;
                        adv = 1'b1;
                    end
                    else
                    begin
                        emit_pend     = 1'b1;
                        ctrl_nxt.mode = MODE_IDLE;
                        fall          = 1'b1;
                    end
                end
                MODE_STRING:
                begin
                    if (byte_req == CH_QUOTE)
                    begin
                        emit_pend     = 1'b1;
                        ctrl_nxt.mode = MODE_IDLE;
                    end
                    else
                    begin
                        tok_nxt.len = (tok_cur.len < LEN_MAX) ? tok_cur.len + 16'd1 : tok_cur.len;
                    end
                    adv = 1'b1;
                end
                default:
                begin
                    fall = 1'b1;
                end
            endcase

            // Handle the byte as fresh input
            if (fall)
            begin
                if (is_blank(byte_req))
                begin
                    adv = 1'b1;
                end
                else if (byte_req == CH_OPEN || byte_req == CH_CLOSE)
                begin
                    emit_here     = 1'b1;
                    here_res.kind = (byte_req == CH_OPEN) ? KIND_OPEN : KIND_CLOSE;
                    here_res.len  = 16'd1;
                    adv           = 1'b1;
                end
                else if (is_letter(byte_req) || byte_req == CH_COLON || is_digit(byte_req))
                begin
                    tok_nxt.line = ctrl_cur.line;
                    tok_nxt.col  = ctrl_cur.col;
                    tok_nxt.off  = ctrl_cur.off;
                    tok_nxt.len  = 16'd1;
                    if (is_digit(byte_req))
                    begin
                        ctrl_nxt.mode = MODE_NUMBER;
                        tok_nxt.acc   = digit_val;
                    end
                    else
                    begin
                        ctrl_nxt.mode = (byte_req == CH_COLON) ? MODE_SYMBOL : MODE_IDENT;
                        tok_nxt.acc   = 32'd0;
                    end
                    adv = 1'b1;
                end
                else if (byte_req == CH_QUOTE)
                begin
                    tok_nxt.line  = ctrl_cur.line;
                    tok_nxt.col   = ctrl_cur.col;
                    tok_nxt.off   = ctrl_cur.off;
                    tok_nxt.len   = 16'd0;
                    tok_nxt.acc   = 32'd0;
                    ctrl_nxt.mode = MODE_STRING;
                    adv           = 1'b1;
                end
                else
                begin
                    emit_here       = 1'b1;
                    here_res.kind   = KIND_BAD;
                    here_res.len    = 16'd1;
                    ctrl_nxt.halted = 1'b1;
                end
            end

            // Advance the position past a consumed byte
            if (adv)
            begin
                ctrl_nxt.off = ctrl_cur.off + 32'd1;
                if (byte_req == CH_NL)
                begin
                    ctrl_nxt.line = (ctrl_cur.line < LINE_MAX) ? ctrl_cur.line + 24'd1
                                                               : ctrl_cur.line;
                    ctrl_nxt.col  = 16'd0;
                end
                else if (ctrl_cur.col < COL_MAX)
                begin
                    ctrl_nxt.col = ctrl_cur.col + 16'd1;
                end
            end
        end
    end

    // Order the results: pending token first, then the one at the current position
    always_comb
    begin
        push.count  = {1'b0, emit_pend} + {1'b0, emit_here};
        push.first  = emit_pend ? pend_res : here_res;
        push.second = here_res;
        push.first.last = !(emit_pend && emit_here);
    end

endmodule

@@ sv/sexp_tok_queue.sv @@
// ----------------------------------------------------------------------------
// sexp_tok_queue
// Result queue: up to two tokens in a cycle, one out a cycle while out_ready.
// ----------------------------------------------------------------------------
module sexp_tok_queue
    import sexp_tok_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  push_t push,
    output logic  room,
    output logic  out_valid,
    input  logic  out_ready,
    output res_t  head
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] ROOM_MAX = CW'(QUEUE_DEPTH - 2);
    localparam logic [CW-1:0] FULL     = CW'(QUEUE_DEPTH);

    res_t          entry_reg [QUEUE_DEPTH];
    logic [PW-1:0] head_reg;
    logic [PW-1:0] head_next;
    logic [PW-1:0] tail_reg;
    logic [PW-1:0] tail_next;
    logic [PW-1:0] tail_plus1;
    logic [PW-1:0] tail_plus2;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          pop;

    function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
        return (p == PTR_LAST) ? '0 : p + PW'(1);
    endfunction

    assign room       = (count_reg <= ROOM_MAX);
    assign out_valid  = (count_reg != '0);
    assign pop        = out_valid && out_ready;
    assign head       = entry_reg[head_reg];
    assign tail_plus1 = wrap_inc(tail_reg);
    assign tail_plus2 = wrap_inc(tail_plus1);

    // Advance pointers and occupancy
    always_comb
    begin
        head_next  = pop ? wrap_inc(head_reg) : head_reg;
        count_next = count_reg + CW'(push.count) - CW'(pop);
        case (push.count)
            2'd1:    tail_next = tail_plus1;
            2'd2:    tail_next = tail_plus2;
            default: tail_next = tail_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // Store new results at the tail
    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            entry_reg[tail_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            entry_reg[tail_plus1] <= push.second;
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL)
        else $error("result queue overfilled");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        (push.count != 2'd0) |-> room)
        else $error("results pushed without room");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (!pop && push.count == 2'd2) |=> count_reg == $past(count_reg) + CW'(2))
        else $error("occupancy lost a double push");
`endif

endmodule

@@ sv/s_expression_tokenizer.sv @@
// ----------------------------------------------------------------------------
// s_expression_tokenizer
// Byte-at-a-time S-expression tokenizer with a result queue.
// ----------------------------------------------------------------------------
// The block takes one source byte (action 0) or an end-of-input mark
// (action 1) per transaction and can accept one in every clock cycle while
// in_ready is high: the scanner state is updated in the same cycle and its
// tokens go into a result queue of QUEUE_DEPTH entries, which delivers one
// token per cycle while out_ready is high. A transaction gives zero,
// one or two tokens, the last one flagged by last; in_ready drops while
// the queue has fewer than two free entries, so a run of two-token items
// is taken at the rate the output drains. After a bad byte or an unclosed
// string the block keeps accepting input but gives no tokens until reset.
module s_expression_tokenizer
    import sexp_tok_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        action,
    input  logic [7:0]  byte_req,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  token_kind,
    output logic [23:0] start_line,
    output logic [15:0] start_column,
    output logic [31:0] start_offset,
    output logic [15:0] token_length,
    output logic [31:0] token_value,
    output logic        last
);

    ctrl_t ctrl_reg;
    ctrl_t ctrl_next;
    tok_t  tok_reg;
    tok_t  tok_next;
    push_t step_push;
    push_t push;
    res_t  head;
    logic  accept;

    assign accept = in_valid && in_ready;

    sexp_tok_step u_step (
        .action   (action),
        .byte_req (byte_req),
        .ctrl_cur (ctrl_reg),
        .tok_cur  (tok_reg),
        .ctrl_nxt (ctrl_next),
        .tok_nxt  (tok_next),
        .push     (step_push)
    );

    // Drop results unless the transaction is taken
    always_comb
    begin
        push = step_push;
        if (!accept)
        begin
            push.count = 2'd0;
        end
    end

    // Hold scanner state between transactions
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg.mode   <= MODE_IDLE;
            ctrl_reg.line   <= 24'd1;
            ctrl_reg.col    <= 16'd0;
            ctrl_reg.off    <= 32'd0;
            ctrl_reg.halted <= 1'b0;
        end
        else if (accept)
        begin
            ctrl_reg <= ctrl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            tok_reg <= tok_next;
        end
    end

    sexp_tok_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head)
    );

    assign token_kind   = head.kind;
    assign start_line   = head.line;
    assign start_column = head.col;
    assign start_offset = head.off;
    assign token_length = head.len;
    assign token_value  = head.val;
    assign last         = head.last;

`ifndef SYNTH
    a_halted_silent: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl_reg.halted |-> step_push.count == 2'd0)
        else $error("tokens produced while halted");

    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        (step_push.count == 2'd2) |-> (!step_push.first.last && step_push.second.last))
        else $error("last flag misplaced in a token pair");

    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl_reg.halted |=> ctrl_reg.halted)
        else $error("halt cleared without reset");
`endif

endmodule

@@ tb/s_expression_tokenizer_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s_expression_tokenizer_tb
// Self-checking testbench of the S-expression tokenizer.
// ----------------------------------------------------------------------------
// A short table of source bytes covers each token kind but the two error
// kinds, the character classes, empty strings, newlines inside strings and
// end-of-input marks. Random fragments (identifiers, symbols, numbers that
// wrap, strings of any bytes but a quote, parentheses, blanks and end marks)
// follow, with random gaps on both sides, a long receiver hold-off and a
// full drain. The run closes with a bad byte or an unclosed string, after
// which the block must stay silent. Every token is checked field by field
// against the pinned token of its table row or a behavioral lexer copy.
// ----------------------------------------------------------------------------
module s_expression_tokenizer_tb;
    import sexp_tok_pkg::*;

    localparam int CYCLE_LIMIT    = 2_000_000;
    localparam int LONG_HOLD      = 300;
    localparam int PHASE_ITEMS    = 62;
    localparam int DRAIN_CYCLES   = 16;

    // Directed row: source byte and, where pinned, the single token it gives
    typedef struct packed {
        logic       act;
        logic [7:0] ch;
        logic       pinned;
        res_t       tok;
    } dir_row_t;

    localparam dir_row_t DIR_TAB [26] = '{
        '{ACT_BYTE, CH_OPEN, 1'b1, '{KIND_OPEN, 24'd1, 16'd0, 32'd0, 16'd1, 32'd0, 1'b1}},
        '{ACT_BYTE, CH_CLOSE, 1'b1, '{KIND_CLOSE, 24'd1, 16'd1, 32'd1, 16'd1, 32'd0, 1'b1}},
        '{act: ACT_BYTE, ch: CH_UNDER, default: '0},
        '{act: ACT_BYTE, ch: "Z", default: '0},
        '{act: ACT_BYTE, ch: CH_NINE, default: '0},
        '{act: ACT_BYTE, ch: CH_BANG, default: '0},
        '{act: ACT_BYTE, ch: CH_QMARK, default: '0},
        '{act: ACT_BYTE, ch: CH_COLON, default: '0},
        '{ACT_BYTE, CH_SPACE, 1'b1, '{KIND_IDENT, 24'd1, 16'd2, 32'd2, 16'd6, 32'd0, 1'b1}},
        '{act: ACT_BYTE, ch: CH_COLON, default: '0},
        '{act: ACT_BYTE, ch: CH_LA, default: '0},
        '{act: ACT_BYTE, ch: CH_OPEN, default: '0},
        '{act: ACT_BYTE, ch: CH_ZERO, default: '0},
        '{act: ACT_BYTE, ch: "4", default: '0},
        '{act: ACT_BYTE, ch: "2", default: '0},
        '{act: ACT_BYTE, ch: CH_TAB, default: '0},
        '{act: ACT_BYTE, ch: CH_QUOTE, default: '0},
        '{ACT_BYTE, CH_QUOTE, 1'b1, '{KIND_STRING, 24'd1, 16'd16, 32'd16, 16'd0, 32'd0, 1'b1}},
        '{act: ACT_BYTE, ch: CH_NL, default: '0},
        '{act: ACT_BYTE, ch: CH_LZ, default: '0},
        '{act: ACT_END, ch: 8'h00, default: '0},
        '{act: ACT_BYTE, ch: CH_QUOTE, default: '0},
        '{act: ACT_BYTE, ch: 8'hFF, default: '0},
        '{act: ACT_BYTE, ch: CH_NL, default: '0},
        '{act: ACT_BYTE, ch: CH_QUOTE, default: '0},
        '{ACT_END, 8'h00, 1'b1, '{KIND_END, 24'd3, 16'd1, 32'd24, 16'd0, 32'd0, 1'b1}}
    };

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        action;
    logic [7:0]  byte_req;
    logic        out_valid;
    logic        out_ready;
    logic [3:0]  token_kind;
    logic [23:0] start_line;
    logic [15:0] start_column;
    logic [31:0] start_offset;
    logic [15:0] token_length;
    logic [31:0] token_value;
    logic        last;

    // Lexer copy: scan position, mode and the token being collected
    mode_t       lex_mode;
    logic [23:0] lex_line;
    logic [15:0] lex_col;
    logic [31:0] lex_off;
    logic        lex_halted;
    logic [23:0] tok_line;
    logic [15:0] tok_col;
    logic [31:0] tok_off;
    logic [15:0] tok_len;
    logic [31:0] tok_val;
    res_t        step_tok [2];
    int          step_cnt;

    // Tokens the block still owes, oldest first
    res_t        token_q [$];

    int          mismatch_count = 0;
    int          cycle_count = 0;
    bit          tx_idle_on = 1'b1;
    bit          rx_idle_on = 1'b1;
    bit          long_hold_req = 1'b0;

    s_expression_tokenizer u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .byte_req     (byte_req),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .token_kind   (token_kind),
        .start_line   (start_line),
        .start_column (start_column),
        .start_offset (start_offset),
        .token_length (token_length),
        .token_value  (token_value),
        .last         (last)
    );

    always #10 clk = ~clk;

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] pick_name_char(input bit lead);
        int sel;
        sel = $urandom_range(lead ? 2 : 6);
        case (sel)
            0: return CH_LA + 8'($urandom_range(25));
            1: return CH_UA + 8'($urandom_range(25));
            2: return CH_UNDER;
            3: return CH_ZERO + 8'($urandom_range(9));
            4: return CH_BANG;
            5: return CH_QMARK;
            default: return CH_COLON;
        endcase
    endfunction

    function automatic void emit_token(input kind_t k, input logic [23:0] ln,
                                       input logic [15:0] col, input logic [31:0] off,
                                       input logic [15:0] len, input logic [31:0] val);
        res_t t;
        t.kind = k;
        t.line = ln;
        t.col  = col;
        t.off  = off;
        t.len  = len;
        t.val  = val;
        t.last = 1'b0;
        step_tok[step_cnt] = t;
        step_cnt++;
    endfunction

    // Emit the token under collection and return to idle
    function automatic void close_pending();
        kind_t       k;
        logic [31:0] v;
        k = KIND_IDENT;
        v = '0;
        case (lex_mode)
            MODE_NUMBER:
            begin
                k = KIND_NUMBER;
                v = tok_val;
            end
            MODE_SYMBOL: k = KIND_SYMBOL;
            MODE_STRING: k = KIND_STRING;
            default: ;
        endcase
        emit_token(k, tok_line, tok_col, tok_off, tok_len, v);
        lex_mode = MODE_IDLE;
    endfunction

    // Advance offset, line and column past one consumed byte
    function automatic void step_position(input logic [7:0] b);
        lex_off++;
        if (b == CH_NL)
        begin
            if (lex_line != LINE_MAX)
                lex_line++;
            lex_col = '0;
        end
        else if (lex_col != COL_MAX)
        begin
            lex_col++;
        end
    endfunction

    // Work out the tokens one transaction completes
    function automatic void lex_item(input logic act, input logic [7:0] b);
        logic is_let;
        logic is_dig;
        logic in_name;
        logic done;
        step_cnt = 0;
        if (lex_halted)
            return;
        is_let  = b inside {[CH_LA:CH_LZ], [CH_UA:CH_UZ], CH_UNDER};
        is_dig  = b inside {[CH_ZERO:CH_NINE]};
        in_name = is_let || is_dig || b inside {CH_BANG, CH_QMARK, CH_COLON};
        done    = 1'b0;

        if (act == ACT_END)
        begin
            if (lex_mode == MODE_STRING)
            begin
                emit_token(KIND_UNCLOSED, tok_line, tok_col, tok_off, tok_len, '0);
                lex_mode   = MODE_IDLE;
                lex_halted = 1'b1;
            end
            else
            begin
                if (lex_mode != MODE_IDLE)
                    close_pending();
                emit_token(KIND_END, lex_line, lex_col, lex_off, '0, '0);
            end
            done = 1'b1;
        end
        else if (lex_mode inside {MODE_IDENT, MODE_SYMBOL, MODE_NUMBER})
        begin
            // Extend the token, or close it and treat the byte as fresh input
            if (lex_mode == MODE_NUMBER ? is_dig : in_name)
            begin
                if (lex_mode == MODE_NUMBER)
                    tok_val = tok_val * 10 + 32'(b - CH_ZERO);
                if (tok_len != LEN_MAX)
                    tok_len++;
                step_position(b);
                done = 1'b1;
            end
            else
            begin
                close_pending();
            end
        end
        else if (lex_mode == MODE_STRING)
        begin
            if (b == CH_QUOTE)
                close_pending();
            else if (tok_len != LEN_MAX)
                tok_len++;
            step_position(b);
            done = 1'b1;
        end

        if (!done)
        begin
            if (b inside {CH_SPACE, CH_NL, CH_TAB})
            begin
                step_position(b);
            end
            else if (b == CH_OPEN || b == CH_CLOSE)
            begin
                emit_token(b == CH_OPEN ? KIND_OPEN : KIND_CLOSE,
                           lex_line, lex_col, lex_off, 16'd1, '0);
                step_position(b);
            end
            else if (is_let || is_dig || b == CH_COLON || b == CH_QUOTE)
            begin
                tok_line = lex_line;
                tok_col  = lex_col;
                tok_off  = lex_off;
                tok_len  = 16'd1;
                tok_val  = '0;
                if (is_dig)
                begin
                    lex_mode = MODE_NUMBER;
                    tok_val  = 32'(b - CH_ZERO);
                end
                else if (b == CH_COLON)
                begin
                    lex_mode = MODE_SYMBOL;
                end
                else if (b == CH_QUOTE)
                begin
                    lex_mode = MODE_STRING;
                    tok_len  = '0;
                end
                else
                begin
                    lex_mode = MODE_IDENT;
                end
                step_position(b);
            end
            else
            begin
                emit_token(KIND_BAD, lex_line, lex_col, lex_off, 16'd1, '0);
                lex_halted = 1'b1;
            end
        end

        if (step_cnt > 0)
            step_tok[step_cnt - 1].last = 1'b1;
    endfunction

    // Offer one transaction, hold it until taken, queue its tokens, then idle for a random gap when enabled
    task automatic offer(input logic act, input logic [7:0] ch,
                         input logic pinned = 1'b0, input res_t pinned_tok = '0);
        int gap;
        in_valid <= 1'b1;
        action   <= act;
        byte_req <= ch;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        lex_item(act, ch);
        if (pinned)
            token_q.push_back(pinned_tok);
        else
            for (int i = 0; i < step_cnt; i++)
                token_q.push_back(step_tok[i]);
        gap = tx_idle_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stop sending until every owed token has come out
    task automatic drain_tokens();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (token_q.size() != 0);
    endtask

    // One random lexical fragment; none of them leaves a bad byte at idle
    task automatic send_fragment();
        int         sel;
        int         n;
        logic [7:0] c;
        sel = $urandom_range(99);
        if (sel < 32)
        begin
            offer(ACT_BYTE, sel < 22 ? pick_name_char(1'b1) : CH_COLON);
            n = $urandom_range(0, 8);
            repeat (n) offer(ACT_BYTE, pick_name_char(1'b0));
        end
        else if (sel < 50)
        begin
            n = ($urandom_range(9) == 0) ? $urandom_range(11, 20) : $urandom_range(1, 6);
            repeat (n) offer(ACT_BYTE, CH_ZERO + 8'($urandom_range(9)));
        end
        else if (sel < 64)
        begin
            offer(ACT_BYTE, CH_QUOTE);
            n = $urandom_range(0, 10);
            repeat (n)
            begin
                do
                    c = 8'($urandom);
                while (c == CH_QUOTE);
                offer(ACT_BYTE, c);
            end
            offer(ACT_BYTE, CH_QUOTE);
        end
        else if (sel < 80)
        begin
            offer(ACT_BYTE, $urandom_range(1) ? CH_OPEN : CH_CLOSE);
        end
        else if (sel < 93)
        begin
            n = $urandom_range(2);
            offer(ACT_BYTE, n == 0 ? CH_SPACE : (n == 1 ? CH_TAB : CH_NL));
        end
        else
        begin
            offer(ACT_END, 8'($urandom));
        end
    endtask

    // Sink: check each token, then pick the next ready level
    initial
    begin
        res_t want;
        int   n;
        int   rx_hold_left;
        rx_hold_left = 0;
        out_ready    = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                if (token_q.size() == 0)
                begin
                    $error("token with nothing owed: kind %0d offset %0d",
                           token_kind, start_offset);
                    mismatch_count++;
                end
                else
                begin
                    want = token_q.pop_front();
                    check_field("token_kind", want.kind, token_kind);
                    check_field("start_line", want.line, start_line);
                    check_field("start_column", want.col, start_column);
                    check_field("start_offset", want.off, start_offset);
                    check_field("token_length", want.len, token_length);
                    check_field("token_value", want.val, token_value);
                    check_field("last", want.last, last);
                end
            end
            if (rx_hold_left > 0)
            begin
                rx_hold_left--;
                out_ready <= 1'b0;
            end
            else if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                rx_hold_left  = LONG_HOLD - 1;
                out_ready    <= 1'b0;
            end
            else
            begin
                n = rx_idle_on ? pick_gap() : 0;
                rx_hold_left = (n > 0) ? n - 1 : 0;
                out_ready   <= (n == 0);
            end
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    // Stimulus
    initial
    begin
        logic [7:0] c;
        clk        = 1'b0;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        action     = ACT_BYTE;
        byte_req   = '0;
        lex_mode   = MODE_IDLE;
        lex_line   = 24'd1;
        lex_col    = '0;
        lex_off    = '0;
        lex_halted = 1'b0;
        tok_line   = '0;
        tok_col    = '0;
        tok_off    = '0;
        tok_len    = '0;
        tok_val    = '0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table
        foreach (DIR_TAB[i])
            offer(DIR_TAB[i].act, DIR_TAB[i].ch, DIR_TAB[i].pinned, DIR_TAB[i].tok);
        drain_tokens();

        // Random fragments in phases with different idling
        for (int phase = 0; phase < 8; phase++)
        begin
            tx_idle_on = (phase % 3 != 1);
            rx_idle_on = (phase % 4 != 1);
            if (phase == 3)
            begin
                // Hold the sink off and keep pushing to fill the block
                in_valid <= 1'b0;
                long_hold_req = 1'b1;
                do
                    @(posedge clk);
                while (long_hold_req);
                tx_idle_on = 1'b0;
                repeat (40) offer(ACT_BYTE, CH_OPEN);
                tx_idle_on = 1'b1;
            end
            if (phase == 5)
                drain_tokens();
            for (int k = 0; k < PHASE_ITEMS; k++)
                send_fragment();
        end

        // Finish with an error that halts the block, then confirm silence
        tx_idle_on = 1'b1;
        if ($urandom_range(1))
        begin
            offer(ACT_BYTE, CH_QUOTE);
            offer(ACT_BYTE, pick_name_char(1'b0));
            offer(ACT_END, 8'($urandom));
        end
        else
        begin
            offer(ACT_BYTE, CH_SPACE);
            do
                c = 8'($urandom);
            while (c inside {[CH_LA:CH_LZ], [CH_UA:CH_UZ], [CH_ZERO:CH_NINE], CH_UNDER,
                             CH_COLON, CH_OPEN, CH_CLOSE, CH_QUOTE, CH_SPACE, CH_NL,
                             CH_TAB});
            offer(ACT_BYTE, c);
        end
        repeat (12) offer(1'($urandom_range(1)), 8'($urandom));

        drain_tokens();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
